// ===== hw/rtl/cpu8_register_alu_execute_core_defines.svh =====
// Assertion macros shared by the execute core modules
`ifndef CPU8_REGISTER_ALU_EXECUTE_CORE_DEFINES_SVH
`define CPU8_REGISTER_ALU_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication, checked at each rising clk outside reset
`define CPU8_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at each rising clk outside reset
`define CPU8_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cpu8_pkg.sv =====
// Shared types and constants for the execute core
package cpu8_pkg;

    typedef enum logic [4:0] {
        OP_LDA = 5'd0,
        OP_LDX = 5'd1,
        OP_LDY = 5'd2,
        OP_STA = 5'd3,
        OP_STX = 5'd4,
        OP_STY = 5'd5,
        OP_TAX = 5'd6,
        OP_TAY = 5'd7,
        OP_TXA = 5'd8,
        OP_TYA = 5'd9,
        OP_TXS = 5'd10,
        OP_TSX = 5'd11,
        OP_PHA = 5'd12,
        OP_PHP = 5'd13,
        OP_PLA = 5'd14,
        OP_PLP = 5'd15,
        OP_AND = 5'd16,
        OP_EOR = 5'd17,
        OP_ORA = 5'd18,
        OP_BIT = 5'd19,
        OP_ADC = 5'd20,
        OP_SBC = 5'd21,
        OP_NOP = 5'd22
    } op_t;

    localparam logic [7:0] STACK_PAGE  = 8'h01;
    localparam logic [7:0] STATUS_INIT = 8'h24;
    localparam int unsigned FLAG_C_BIT = 0;
    localparam int unsigned FLAG_Z_BIT = 1;
    localparam int unsigned FLAG_B_BIT = 4;
    localparam int unsigned FLAG_U_BIT = 5;
    localparam int unsigned FLAG_V_BIT = 6;
    localparam int unsigned FLAG_N_BIT = 7;

    typedef struct packed {
        logic store;
        logic push;
        logic pull;
    } op_class_t;

    typedef struct packed {
        op_t         op;
        op_class_t   cls;
        logic [7:0]  operand;
        logic [15:0] address;
    } item_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] read_address;
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack;
        logic [7:0]  status;
    } result_t;

endpackage

// ===== hw/rtl/cpu8_register_alu_execute_core.sv =====
// Top level of the 8-bit register and ALU execute core
// Takes one resolved instruction per beat (operation, operand byte, effective
// address) and returns one beat with any memory write, the stack read address
// and the register file after the instruction. One instruction per cycle is
// sustained while m_axis_tready stays high; a result passes the queue and the
// output register. The rate is set by the register file and ALU update in the
// execute unit. A two-entry queue between decode and execute, plus the output
// register, lets input keep flowing while a result waits on m_axis_tready.
module cpu8_register_alu_execute_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [4:0]   s_axis_tuser,   // operation
    input  logic [23:0]  s_axis_tdata,   // operand [7:0], address [23:8]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic         m_axis_tuser,   // write_enable
    output logic [79:0]  m_axis_tdata    // write_address, write_data, read_address,
                                         // acc_out, index_x_out, index_y_out,
                                         // stack_out, status_out
);
    import cpu8_pkg::*;

    logic     push;
    item_t    push_item;
    logic     queue_ready;
    logic     pop;
    item_t    pop_item;
    logic     pop_valid;
    result_t  result;

    cpu8_decode u_decode (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_item     (push_item),
        .queue_ready   (queue_ready)
    );

    cpu8_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (queue_ready),
        .pop       (pop),
        .pop_item  (pop_item),
        .pop_valid (pop_valid)
    );

    cpu8_execute u_execute (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item       (pop_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tuser = result.write_enable;
    assign m_axis_tdata = {result.status, result.stack, result.index_y, result.index_x,
                           result.acc, result.read_address, result.write_data,
                           result.write_address};

endmodule

// ===== hw/rtl/cpu8_decode.sv =====
// Front end: accept instruction beats and classify them for the queue
module cpu8_decode (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [4:0]         s_axis_tuser,   // operation
    input  logic [23:0]        s_axis_tdata,   // operand [7:0], address [23:8]
    output logic               push,
    output cpu8_pkg::item_t    push_item,
    input  logic               queue_ready
);
    import cpu8_pkg::*;

    op_t op;

    always_comb
    begin
        if (s_axis_tuser inside {[5'd0:5'd22]})
        begin
            op = op_t'(s_axis_tuser);
        end
        else
        begin
            op = OP_NOP;
        end
    end

    always_comb
    begin
        push_item.op       = op;
        push_item.operand  = s_axis_tdata[7:0];
        push_item.address  = s_axis_tdata[23:8];
        push_item.cls.store = (op == OP_STA) || (op == OP_STX) || (op == OP_STY);
        push_item.cls.push  = (op == OP_PHA) || (op == OP_PHP);
        push_item.cls.pull  = (op == OP_PLA) || (op == OP_PLP);
    end

    assign s_axis_tready = queue_ready;
    assign push          = s_axis_tvalid && queue_ready;

endmodule

// ===== hw/rtl/cpu8_queue.sv =====
// Two-entry queue between decode and execute
module cpu8_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cpu8_pkg::item_t    push_item,
    output logic               ready,
    input  logic               pop,
    output cpu8_pkg::item_t    pop_item,
    output logic               pop_valid
);
    import cpu8_pkg::*;
    `include "cpu8_register_alu_execute_core_defines.svh"

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign ready     = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    `CPU8_ASSERT_IMP(a_no_overflow, push, count_reg != 2'd2, "push into full queue")
    `CPU8_ASSERT_IMP(a_no_underflow, pop, count_reg != 2'd0, "pop from empty queue")
    `CPU8_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 2'd1,
        "queue count did not advance on push")

endmodule

// ===== hw/rtl/cpu8_execute.sv =====
// Back end: register file, ALU and output register
module cpu8_execute (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  cpu8_pkg::item_t    item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output cpu8_pkg::result_t  out_result
);
    import cpu8_pkg::*;
    `include "cpu8_register_alu_execute_core_defines.svh"

    logic [7:0] a_reg;
    logic [7:0] a_next;
    logic [7:0] x_reg;
    logic [7:0] x_next;
    logic [7:0] y_reg;
    logic [7:0] y_next;
    logic [7:0] sp_reg;
    logic [7:0] sp_next;
    logic [7:0] p_reg;
    logic [7:0] p_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    res_reg;
    result_t    res_next;

    logic [7:0] sp_inc;
    logic [7:0] sp_dec;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] nz_val;
    logic       nz_en;

    assign pop            = item_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = pop || (out_valid_reg && !out_ready);

    assign sp_inc = sp_reg + 8'd1;
    assign sp_dec = sp_reg - 8'd1;
    assign addend = (item.op == OP_SBC) ? ~item.operand : item.operand;
    assign sum    = {1'b0, a_reg} + {1'b0, addend} + {8'd0, p_reg[FLAG_C_BIT]};

    always_comb
    begin
        a_next  = a_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        sp_next = sp_reg;
        p_next  = p_reg;
        nz_val  = 8'd0;
        nz_en   = 1'b0;
        res_next.write_enable  = 1'b0;
        res_next.write_address = 16'd0;
        res_next.write_data    = 8'd0;
        res_next.read_address  = item.address;
        case (item.op)
            OP_LDA:
            begin
                a_next = item.operand;
                nz_val = item.operand;
                nz_en  = 1'b1;
            end
            OP_LDX:
            begin
                x_next = item.operand;
                nz_val = item.operand;
                nz_en  = 1'b1;
            end
            OP_LDY:
            begin
                y_next = item.operand;
                nz_val = item.operand;
                nz_en  = 1'b1;
            end
            OP_STA: res_next.write_data = a_reg;
            OP_STX: res_next.write_data = x_reg;
            OP_STY: res_next.write_data = y_reg;
            OP_TAX:
            begin
                x_next = a_reg;
                nz_val = a_reg;
                nz_en  = 1'b1;
            end
            OP_TAY:
            begin
                y_next = a_reg;
                nz_val = a_reg;
                nz_en  = 1'b1;
            end
            OP_TXA:
            begin
                a_next = x_reg;
                nz_val = x_reg;
                nz_en  = 1'b1;
            end
            OP_TYA:
            begin
                a_next = y_reg;
                nz_val = y_reg;
                nz_en  = 1'b1;
            end
            OP_TXS: sp_next = x_reg;
            OP_TSX:
            begin
                x_next = sp_reg;
                nz_val = sp_reg;
                nz_en  = 1'b1;
            end
            OP_PHA: res_next.write_data = a_reg;
            OP_PHP:
            begin
                res_next.write_data = p_reg;
                res_next.write_data[FLAG_B_BIT] = 1'b1;
                res_next.write_data[FLAG_U_BIT] = 1'b1;
            end
            OP_PLA:
            begin
                a_next = item.operand;
                nz_val = item.operand;
                nz_en  = 1'b1;
            end
            OP_PLP:
            begin
                p_next = item.operand;
                p_next[FLAG_B_BIT] = 1'b0;
            end
            OP_AND:
            begin
                a_next = a_reg & item.operand;
                nz_val = a_reg & item.operand;
                nz_en  = 1'b1;
            end
            OP_EOR:
            begin
                a_next = a_reg ^ item.operand;
                nz_val = a_reg ^ item.operand;
                nz_en  = 1'b1;
            end
            OP_ORA:
            begin
                a_next = a_reg | item.operand;
                nz_val = a_reg | item.operand;
                nz_en  = 1'b1;
            end
            OP_BIT:
            begin
                p_next[FLAG_Z_BIT] = ((a_reg & item.operand) == 8'd0);
                p_next[FLAG_N_BIT] = item.operand[7];
                p_next[FLAG_V_BIT] = item.operand[6];
            end
            OP_ADC, OP_SBC:
            begin
                a_next = sum[7:0];
                nz_val = sum[7:0];
                nz_en  = 1'b1;
                p_next[FLAG_C_BIT] = sum[8];
                p_next[FLAG_V_BIT] = (a_reg[7] ^ sum[7]) & (addend[7] ^ sum[7]);
            end
            default:
            begin
            end
        endcase

        if (item.cls.store)
        begin
            res_next.write_enable  = 1'b1;
            res_next.write_address = item.address;
        end
        if (item.cls.push)
        begin
            res_next.write_enable  = 1'b1;
            res_next.write_address = {STACK_PAGE, sp_reg};
            sp_next                = sp_dec;
        end
        if (item.cls.pull)
        begin
            sp_next               = sp_inc;
            res_next.read_address = {STACK_PAGE, sp_inc};
        end
        if (nz_en)
        begin
            p_next[FLAG_Z_BIT] = (nz_val == 8'd0);
            p_next[FLAG_N_BIT] = nz_val[7];
        end
        p_next[FLAG_U_BIT] = 1'b1;

        res_next.acc     = a_next;
        res_next.index_x = x_next;
        res_next.index_y = y_next;
        res_next.stack   = sp_next;
        res_next.status  = p_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= 8'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            sp_reg        <= 8'd0;
            p_reg         <= STATUS_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                a_reg  <= a_next;
                x_reg  <= x_next;
                y_reg  <= y_next;
                sp_reg <= sp_next;
                p_reg  <= p_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    `CPU8_ASSERT_IMP(a_status_u, 1'b1, p_reg[FLAG_U_BIT], "status bit 5 clear")
    `CPU8_ASSERT_IMP(a_no_overwrite, pop && out_valid_reg, out_ready,
        "result register overwritten while stalled")
    `CPU8_ASSERT_NXT(a_push_sp, pop && item.cls.push, sp_reg == $past(sp_reg) - 8'd1,
        "stack pointer did not drop on push")

endmodule
